### rtl/core/mrq_pkg.sv
`default_nettype none
package mrq_pkg;

    localparam int MAX_FRAME       = 32;
    localparam int CNT_W           = 6;
    localparam int SHORT_FRAME_MAX = 4;
    localparam int REQ_BEATS       = 8;
    localparam int BEAT_W          = 3;

    localparam logic [7:0]  REG_COUNT_HI = 8'h00;
    localparam logic [7:0]  REG_COUNT_LO = 8'h02;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_ORDER = 3'd4;

    typedef enum logic [1:0] {
        CMD_RX_BYTE   = 2'd0,
        CMD_FRAME_END = 2'd1,
        CMD_START     = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FS_OK      = 2'd0,
        FS_SHORT   = 2'd1,
        FS_CRC     = 2'd2,
        FS_OVERRUN = 2'd3
    } t_fs;

    typedef enum logic [1:0] {
        QS_VALUE      = 2'd0,
        QS_TIMEOUT    = 2'd1,
        QS_WRONG_CODE = 2'd2
    } t_qs;

    typedef enum logic [1:0] {
        TXM_REQ,
        TXM_FRAME,
        TXM_FRAME_DONE,
        TXM_TIMEOUT
    } t_tx_mode;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        t_fs         frame_status;
        t_qs         query_status;
        logic [31:0] flow_value;
    } t_out;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [7:0]  func_code;
        logic [15:0] reg_addr;
        logic        crc_high_first;
    } t_req_cfg;

    typedef struct packed {
        t_tx_mode    mode;
        t_fs         fs;
        t_qs         qs;
        logic [31:0] value;
    } t_tx_desc;

    typedef struct packed {
        t_fs         fs;
        logic [7:0]  code;
        logic [31:0] value;
    } t_rx_stat;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mrq_rx.sv
`default_nettype none
module mrq_rx (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_byte_en,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_frame_end,
    input  wire logic              i_crc_high_first,
    output mrq_pkg::t_rx_stat      o_stat
);
    import mrq_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_crc;
    logic [7:0]       r_lag0;
    logic [7:0]       r_lag1;
    logic             r_overrun;
    logic [7:0]       r_code;
    logic [31:0]      r_value;
    logic [15:0]      got;

    always_comb begin
        got = i_crc_high_first ? {r_lag0, r_lag1} : {r_lag1, r_lag0};
        o_stat.code  = r_code;
        o_stat.value = r_value;
        priority if (r_overrun) begin
            o_stat.fs = FS_OVERRUN;
        end else if (r_cnt <= CNT_W'(SHORT_FRAME_MAX)) begin
            o_stat.fs = FS_SHORT;
        end else if (got != r_crc) begin
            o_stat.fs = FS_CRC;
        end else begin
            o_stat.fs = FS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_crc     <= CRC_INIT;
            r_lag0    <= '0;
            r_lag1    <= '0;
            r_overrun <= 1'b0;
            r_code    <= '0;
            r_value   <= '0;
        end else if (i_frame_end) begin
            r_cnt     <= '0;
            r_crc     <= CRC_INIT;
            r_lag0    <= '0;
            r_lag1    <= '0;
            r_overrun <= 1'b0;
        end else if (i_byte_en) begin
            if (r_cnt >= CNT_W'(MAX_FRAME)) begin
                r_overrun <= 1'b1;
            end else begin
                case (r_cnt)
                    CNT_W'(0): r_value        <= '0;
                    CNT_W'(1): r_code         <= i_byte;
                    CNT_W'(3): r_value[31:24] <= i_byte;
                    CNT_W'(4): r_value[23:16] <= i_byte;
                    CNT_W'(5): r_value[15:8]  <= i_byte;
                    CNT_W'(6): r_value[7:0]   <= i_byte;
                    default: ;
                endcase
                // CRC trails by two bytes so the frame's own CRC stays out
                if (r_cnt >= CNT_W'(2)) begin
                    r_crc <= crc_feed(r_crc, r_lag0);
                end
                r_lag0 <= r_lag1;
                r_lag1 <= i_byte;
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/mrq_tx.sv
`default_nettype none
module mrq_tx (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire mrq_pkg::t_tx_desc i_desc,
    input  wire mrq_pkg::t_req_cfg i_cfg,
    output logic                   o_load_ok,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mrq_pkg::t_out          o_out
);
    import mrq_pkg::*;

    logic              r_busy;
    t_tx_desc          r_desc;
    logic [BEAT_W-1:0] r_idx;
    logic [15:0]       r_crc;
    logic [7:0]        req_byte;
    logic              beat_done;

    always_comb begin
        unique case (r_idx)
            3'd0: req_byte = i_cfg.dev_addr;
            3'd1: req_byte = i_cfg.func_code;
            3'd2: req_byte = i_cfg.reg_addr[15:8];
            3'd3: req_byte = i_cfg.reg_addr[7:0];
            3'd4: req_byte = REG_COUNT_HI;
            3'd5: req_byte = REG_COUNT_LO;
            3'd6: req_byte = i_cfg.crc_high_first ? r_crc[15:8] : r_crc[7:0];
            default: req_byte = i_cfg.crc_high_first ? r_crc[7:0] : r_crc[15:8];
        endcase
    end

    always_comb begin
        o_out              = '0;
        o_out.kind         = KIND_REPORT;
        o_out.frame_status = FS_OK;
        o_out.query_status = QS_VALUE;
        unique case (r_desc.mode)
            TXM_REQ: begin
                o_out.kind    = KIND_TX;
                o_out.tx_byte = req_byte;
                o_out.last    = (r_idx == BEAT_W'(REQ_BEATS - 1));
            end
            TXM_FRAME: begin
                o_out.frame_status = r_desc.fs;
                o_out.last         = 1'b1;
            end
            TXM_FRAME_DONE: begin
                if (r_idx != '0) begin
                    o_out.kind         = KIND_DONE;
                    o_out.query_status = r_desc.qs;
                    o_out.flow_value   = r_desc.value;
                    o_out.last         = 1'b1;
                end
            end
            default: begin
                o_out.kind         = KIND_DONE;
                o_out.query_status = QS_TIMEOUT;
                o_out.last         = 1'b1;
            end
        endcase
    end

    assign o_out_valid = r_busy;
    assign beat_done   = r_busy && i_out_ready;
    assign o_load_ok   = !r_busy || (i_out_ready && o_out.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
            r_desc <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_desc <= i_desc;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
        end else if (beat_done) begin
            if (o_out.last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + BEAT_W'(1);
                // fold each header byte into the CRC as it goes out
                if (r_desc.mode == TXM_REQ && r_idx < BEAT_W'(6)) begin
                    r_crc <= crc_feed(r_crc, req_byte);
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/modbus_rtu_register_query.sv
// Modbus RTU master for one read-registers query.
// Input channel (i_in_valid / o_in_ready, i_in): one beat per event: a received
// byte, a frame end (line silence), a start request or a time tick.
// Output channel (o_out_valid / i_out_ready, o_out): transmit bytes, frame
// check reports and query-done beats; 'last' marks the final beat of an event.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; write only while the block is idle.
// An input beat is registered in the input register, then handled; its first
// result is registered in the output emitter and offered from there. Events
// with no result (bytes, ticks, ignored starts) flow at one per cycle. The
// output emitter holds one event: a start takes 8 output beats (the request
// CRC is built one byte per beat), a good frame during a query takes 2,
// others take 1. The next event loads as the last beat of the current one is
// taken, so back-to-back events keep the output busy every cycle.
// When the receiver stalls, the emitter holds its beat, the input register
// waits on a result-producing event, and o_in_ready drops.
// Synchronous reset restores default config, idle query state and an empty
// receiver; no output is pending after reset.
`default_nettype none
module modbus_rtu_register_query (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire mrq_pkg::t_in                      i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output mrq_pkg::t_out                          o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mrq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mrq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mrq_pkg::*;

    logic        r_in_vld;
    t_in         r_in;
    t_req_cfg    r_req_cfg;
    logic [15:0] r_timeout;
    logic        r_waiting;
    logic [15:0] r_ticks;
    logic [15:0] n_ticks;
    logic        n_waiting;

    t_rx_stat    rx_stat;
    t_tx_desc    desc;
    logic        need_desc;
    logic        load_ok;
    logic        proc_go;
    logic        byte_en;
    logic        frame_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_cfg.dev_addr       <= 8'd1;
            r_req_cfg.func_code      <= 8'd3;
            r_req_cfg.reg_addr       <= 16'd2;
            r_req_cfg.crc_high_first <= 1'b1;
            r_timeout                <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEV_ADDR:  r_req_cfg.dev_addr       <= i_cfg_data[7:0];
                CFG_FUNC_CODE: r_req_cfg.func_code      <= i_cfg_data[7:0];
                CFG_REG_ADDR:  r_req_cfg.reg_addr       <= i_cfg_data;
                CFG_TIMEOUT:   r_timeout                <= i_cfg_data;
                CFG_CRC_ORDER: r_req_cfg.crc_high_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        need_desc  = 1'b0;
        n_waiting  = r_waiting;
        n_ticks    = r_ticks;
        desc       = '0;
        desc.mode  = TXM_FRAME;
        desc.fs    = rx_stat.fs;
        desc.qs    = QS_VALUE;
        unique case (r_in.cmd)
            CMD_RX_BYTE: ;
            CMD_FRAME_END: begin
                need_desc = 1'b1;
                if (rx_stat.fs == FS_OK && r_waiting) begin
                    desc.mode = TXM_FRAME_DONE;
                    n_waiting = 1'b0;
                    n_ticks   = '0;
                    if (rx_stat.code == r_req_cfg.func_code) begin
                        desc.value = rx_stat.value;
                    end else begin
                        desc.qs = QS_WRONG_CODE;
                    end
                end
            end
            CMD_START: begin
                if (!r_waiting) begin
                    need_desc = 1'b1;
                    desc.mode = TXM_REQ;
                    n_waiting = 1'b1;
                    n_ticks   = r_timeout;
                end
            end
            default: begin
                if (r_waiting) begin
                    if (r_ticks <= 16'd1) begin
                        need_desc = 1'b1;
                        desc.mode = TXM_TIMEOUT;
                        n_waiting = 1'b0;
                        n_ticks   = '0;
                    end else begin
                        n_ticks = r_ticks - 16'd1;
                    end
                end
            end
        endcase
    end

    assign proc_go    = r_in_vld && (!need_desc || load_ok);
    assign o_in_ready = !r_in_vld || proc_go;
    assign byte_en    = proc_go && (r_in.cmd == CMD_RX_BYTE);
    assign frame_end  = proc_go && (r_in.cmd == CMD_FRAME_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_in      <= '0;
            r_waiting <= 1'b0;
            r_ticks   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in;
                end
            end
            if (proc_go) begin
                r_waiting <= n_waiting;
                r_ticks   <= n_ticks;
            end
        end
    end

    mrq_rx u_rx (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte_en        (byte_en),
        .i_byte           (r_in.rx_byte),
        .i_frame_end      (frame_end),
        .i_crc_high_first (r_req_cfg.crc_high_first),
        .o_stat           (rx_stat)
    );

    mrq_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (proc_go && need_desc),
        .i_desc      (desc),
        .i_cfg       (r_req_cfg),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

### tb/sv/modbus_rtu_register_query_tb.sv
`timescale 1ns / 100ps

module modbus_rtu_register_query_tb;
    import mrq_pkg::*;

    localparam int RANDOM_ITEMS  = 290;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_NS   = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  src_valid = 1'b0;
    t_in                   src_item  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  sink_ready = 1'b0;
    t_out                  out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit          no_gaps  = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned items_sent;
    int unsigned mismatch_count;

    // query master mirror: register copies and state
    logic [7:0]  par_dev;
    logic [7:0]  par_code;
    logic [15:0] par_reg;
    logic [15:0] par_timeout;
    logic        par_crc_hi;
    bit          waiting;
    logic [15:0] ticks_left;
    int unsigned rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  lag0;
    logic [7:0]  lag1;
    logic [7:0]  cap_code;
    logic [31:0] cap_value;
    bit          rx_overrun;

    t_out query_beats_due[$];

    modbus_rtu_register_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (src_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (src_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (sink_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_modbus_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_receiver();
        rx_count   = 0;
        rx_crc     = CRC_INIT;
        lag0       = 8'h00;
        lag1       = 8'h00;
        rx_overrun = 1'b0;
    endfunction

    function automatic void reset_query_model();
        par_dev     = 8'd1;
        par_code    = 8'd3;
        par_reg     = 16'd2;
        par_timeout = 16'd1000;
        par_crc_hi  = 1'b1;
        waiting     = 1'b0;
        ticks_left  = 16'd0;
        cap_code    = 8'h00;
        cap_value   = 32'h0;
        clear_receiver();
    endfunction

    function automatic void queue_beat(t_kind k, logic [7:0] tx, logic lst, t_fs fs, t_qs qs,
                                       logic [31:0] v);
        t_out b;
        b.kind         = k;
        b.tx_byte      = tx;
        b.last         = lst;
        b.frame_status = fs;
        b.query_status = qs;
        b.flow_value   = v;
        query_beats_due.push_back(b);
    endfunction

    function automatic void predict_query_beats(t_in item);
        logic [7:0]  req[8];
        logic [15:0] crc;
        logic [15:0] got;
        t_fs         fs;
        case (item.cmd)
            CMD_RX_BYTE: begin
                if (rx_count >= MAX_FRAME) begin
                    rx_overrun = 1'b1;
                end else begin
                    if (rx_count == 0) begin
                        cap_value = 32'h0;
                    end else if (rx_count == 1) begin
                        cap_code = item.rx_byte;
                    end else if (rx_count >= 3 && rx_count <= 6) begin
                        cap_value |= 32'(item.rx_byte) << (8 * (6 - rx_count));
                    end
                    // CRC runs two bytes behind so the trailing pair stays out
                    if (rx_count >= 2) begin
                        rx_crc = crc16_modbus_step(rx_crc, lag0);
                    end
                    lag0 = lag1;
                    lag1 = item.rx_byte;
                    rx_count++;
                end
            end
            CMD_FRAME_END: begin
                got = par_crc_hi ? {lag0, lag1} : {lag1, lag0};
                if (rx_overrun) begin
                    fs = FS_OVERRUN;
                end else if (rx_count <= SHORT_FRAME_MAX) begin
                    fs = FS_SHORT;
                end else if (got != rx_crc) begin
                    fs = FS_CRC;
                end else begin
                    fs = FS_OK;
                end
                clear_receiver();
                if (fs != FS_OK || !waiting) begin
                    queue_beat(KIND_REPORT, 8'h00, 1'b1, fs, QS_VALUE, 32'h0);
                end else begin
                    waiting    = 1'b0;
                    ticks_left = 16'd0;
                    queue_beat(KIND_REPORT, 8'h00, 1'b0, FS_OK, QS_VALUE, 32'h0);
                    if (cap_code == par_code) begin
                        queue_beat(KIND_DONE, 8'h00, 1'b1, FS_OK, QS_VALUE, cap_value);
                    end else begin
                        queue_beat(KIND_DONE, 8'h00, 1'b1, FS_OK, QS_WRONG_CODE, 32'h0);
                    end
                end
            end
            CMD_START: begin
                if (!waiting) begin
                    req[0] = par_dev;
                    req[1] = par_code;
                    req[2] = par_reg[15:8];
                    req[3] = par_reg[7:0];
                    req[4] = REG_COUNT_HI;
                    req[5] = REG_COUNT_LO;
                    crc = CRC_INIT;
                    for (int i = 0; i < 6; i++) begin
                        crc = crc16_modbus_step(crc, req[i]);
                    end
                    req[6] = par_crc_hi ? crc[15:8] : crc[7:0];
                    req[7] = par_crc_hi ? crc[7:0] : crc[15:8];
                    for (int i = 0; i < REQ_BEATS; i++) begin
                        queue_beat(KIND_TX, req[i], i == REQ_BEATS - 1, FS_OK, QS_VALUE, 32'h0);
                    end
                    waiting    = 1'b1;
                    ticks_left = par_timeout;
                end
            end
            default: begin
                if (waiting) begin
                    if (ticks_left <= 1) begin
                        waiting    = 1'b0;
                        ticks_left = 16'd0;
                        queue_beat(KIND_DONE, 8'h00, 1'b1, FS_OK, QS_TIMEOUT, 32'h0);
                    end else begin
                        ticks_left--;
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && sink_ready) begin
            if (query_beats_due.size() == 0) begin
                $error("unexpected beat: kind 0x%0h", out_beat.kind);
                mismatch_count++;
            end else begin
                want = query_beats_due.pop_front();
                check_field("kind", want.kind, out_beat.kind);
                check_field("tx_byte", want.tx_byte, out_beat.tx_byte);
                check_field("last", want.last, out_beat.last);
                check_field("frame_status", want.frame_status, out_beat.frame_status);
                check_field("query_status", want.query_status, out_beat.query_status);
                check_field("flow_value", want.flow_value, out_beat.flow_value);
            end
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                sink_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                sink_ready <= no_gaps || ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("modbus_rtu_register_query: mismatch");
        $finish;
    end

    task automatic send_item(t_cmd c, logic [7:0] b);
        t_in item;
        item.cmd     = c;
        item.rx_byte = b;
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 26) begin
            src_valid <= 1'b0;
            @(negedge i_clk);
        end
        src_valid <= 1'b1;
        src_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_query_beats(item);
        items_sent++;
    endtask

    task automatic send_random_byte();
        send_item(CMD_RX_BYTE, 8'($urandom_range(255)));
    endtask

    // reply: address, code, byte count, value bytes, filler, CRC in set order
    task automatic send_reply(logic [7:0] code, logic [31:0] value, int body_len, bit corrupt);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          pos;
        frame.push_back(par_dev);
        frame.push_back(code);
        frame.push_back(8'd4);
        for (int i = 3; i >= 0; i--) begin
            frame.push_back(value[8*i +: 8]);
        end
        while (frame.size() < body_len) frame.push_back(8'($urandom_range(255)));
        while (frame.size() > body_len) void'(frame.pop_back());
        crc = CRC_INIT;
        foreach (frame[i]) crc = crc16_modbus_step(crc, frame[i]);
        frame.push_back(par_crc_hi ? crc[15:8] : crc[7:0]);
        frame.push_back(par_crc_hi ? crc[7:0] : crc[15:8]);
        if (corrupt) begin
            pos = $urandom_range(frame.size() - 1);
            frame[pos][$urandom_range(7)] ^= 1'b1;
        end
        foreach (frame[i]) send_item(CMD_RX_BYTE, frame[i]);
        send_item(CMD_FRAME_END, 8'($urandom_range(255)));
    endtask

    // drop valid and let every expected beat drain before touching registers
    task automatic drain();
        @(negedge i_clk);
        src_valid <= 1'b0;
        while (query_beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DEV_ADDR:  par_dev     = data[7:0];
            CFG_FUNC_CODE: par_code    = data[7:0];
            CFG_REG_ADDR:  par_reg     = data;
            CFG_TIMEOUT:   par_timeout = data;
            CFG_CRC_ORDER: par_crc_hi  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value(int width);
        logic [15:0] v;
        case ($urandom_range(3))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            default: v = 16'($urandom_range(65535));
        endcase
        return (width == 8) ? {8'h00, v[7:0]} : v;
    endfunction

    task automatic settle_query();
        while (waiting) send_reply(par_code, $urandom, 7, 1'b0);
        drain();
    endtask

    task automatic load_random_settings();
        logic [15:0] tmo;
        case ($urandom_range(5))
            0:       tmo = 16'hFFFF;
            1:       tmo = 16'd1;
            default: tmo = 16'($urandom_range(2, 8));
        endcase
        settle_query();
        // upper data bits of narrow registers carry noise
        write_reg(CFG_DEV_ADDR, pick_value(8) | {8'($urandom_range(255)), 8'h00});
        write_reg(CFG_FUNC_CODE, pick_value(8) | {8'($urandom_range(255)), 8'h00});
        write_reg(CFG_REG_ADDR, pick_value(16));
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_CRC_ORDER, 16'($urandom_range(65535)));
    endtask

    task automatic test_idle_events();
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_FRAME_END, 8'h00);
        send_item(CMD_RX_BYTE, 8'h00);
        send_item(CMD_RX_BYTE, 8'hFF);
        send_item(CMD_FRAME_END, 8'hA5);
        drain();
    endtask

    task automatic test_request_and_reply();
        send_item(CMD_START, 8'h00);
        send_item(CMD_START, 8'hFF);
        send_item(CMD_TICK, 8'h5A);
        send_reply(par_code, 32'hFF00_00FF, 7, 1'b0);
        drain();
    endtask

    task automatic test_timeouts();
        write_reg(CFG_TIMEOUT, 16'h0000);
        write_reg(CFG_CRC_ORDER, 16'h0000);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        drain();
        write_reg(CFG_TIMEOUT, 16'h0001);
        write_reg(CFG_DEV_ADDR, 16'h00FF);
        write_reg(CFG_FUNC_CODE, 16'h0000);
        write_reg(CFG_REG_ADDR, 16'hFFFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        drain();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        send_item(CMD_START, 8'h00);
        // short reply with the wrong code ends the query early
        send_reply(8'hFF, 32'h1234_5678, 3, 1'b0);
        drain();
    endtask

    task automatic test_back_pressure();
        hold_req = 1'b1;
        repeat (3) begin
            send_item(CMD_START, 8'($urandom_range(255)));
            send_reply(par_code, $urandom, 7, 1'b0);
            send_item(CMD_FRAME_END, 8'($urandom_range(255)));
        end
        drain();
    endtask

    task automatic run_random_query();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            send_item(CMD_START, 8'($urandom_range(255)));
            repeat ($urandom_range(3)) send_item(CMD_TICK, 8'($urandom_range(255)));
            send_reply(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : par_code,
                       $urandom,
                       ($urandom_range(4) == 0) ? $urandom_range(1, 10) : 7,
                       $urandom_range(6) == 0);
        end else if (r < 65) begin
            send_item(CMD_START, 8'($urandom_range(255)));
            repeat ($urandom_range(1, 9)) send_item(CMD_TICK, 8'($urandom_range(255)));
        end else if (r < 75) begin
            repeat ($urandom_range(6)) send_random_byte();
            send_item(CMD_FRAME_END, 8'($urandom_range(255)));
        end else if (r < 80) begin
            repeat ($urandom_range(MAX_FRAME + 1, MAX_FRAME + 4)) send_random_byte();
            send_item(CMD_FRAME_END, 8'($urandom_range(255)));
        end else if (r < 90) begin
            send_item(t_cmd'($urandom_range(1, 3)), 8'($urandom_range(255)));
        end else begin
            send_reply(par_code, $urandom, 7, 1'b0);
        end
    endtask

    task automatic test_random_queries();
        int unsigned first;
        int unsigned phase_first;
        int          phase;
        first = items_sent;
        phase = 0;
        while (items_sent - first < RANDOM_ITEMS) begin
            load_random_settings();
            no_gaps     = (phase == 2);
            phase_first = items_sent;
            while (items_sent - phase_first < PHASE_ITEMS &&
                   items_sent - first < RANDOM_ITEMS) begin
                run_random_query();
            end
            no_gaps = 1'b0;
            phase++;
        end
        settle_query();
    endtask

    initial begin
        items_sent     = 0;
        mismatch_count = 0;
        reset_query_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_events();
        test_request_and_reply();
        test_timeouts();
        test_back_pressure();
        test_random_queries();
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("modbus_rtu_register_query: match");
        end else begin
            $display("modbus_rtu_register_query: mismatch");
        end
        $finish;
    end

endmodule

### modbus_rtu_register_query.f
rtl/core/mrq_pkg.sv
rtl/core/mrq_rx.sv
rtl/core/mrq_tx.sv
rtl/core/modbus_rtu_register_query.sv
tb/sv/modbus_rtu_register_query_tb.sv
